>>> src/clcd_pkg.sv
package clcd_pkg;

    localparam int QUEUE_DEPTH = 4;

    // request codes
    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_NIBBLE = 3'd1;
    localparam logic [2:0] ACT_BYTE   = 3'd2;
    localparam logic [2:0] ACT_CHAR   = 3'd3;
    localparam logic [2:0] ACT_CURSOR = 3'd4;

    // job kinds handed to the back end
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_NIBBLE = 2'd1;
    localparam logic [1:0] OP_BYTE   = 2'd2;

    localparam logic [15:0] STROBE_US    = 16'd1;
    localparam logic [15:0] CHAR_WAIT_US = 16'd43;
    localparam logic [15:0] SETTLE_US    = 16'd50000;

    localparam logic [4:0] INIT_LAST_STEP   = 5'd28;
    localparam logic [4:0] NIBBLE_LAST_STEP = 5'd1;
    localparam logic [4:0] BYTE_LAST_STEP   = 5'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic        rs;
        logic [15:0] wait_us;
    } lcd_job_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic        en;
        logic [15:0] hold_us;
    } pin_state_t;

    // power-up sequence, one pin state per step
    // after the settle step, odd steps strobe high and even steps wait low
    function automatic pin_state_t init_step(input logic [4:0] step);
        pin_state_t p;
        p.rs = 1'b0;
        p.en = step[0];
        p.hold_us = STROBE_US;
        p.nibble = 4'h0;
        case (step)
            5'd0: begin
                p.en = 1'b0;
                p.hold_us = SETTLE_US;
            end
            5'd1, 5'd3, 5'd5: p.nibble = 4'h3;
            5'd2: begin
                p.nibble = 4'h3;
                p.hold_us = 16'd4100;
            end
            5'd4, 5'd6: begin
                p.nibble = 4'h3;
                p.hold_us = 16'd100;
            end
            5'd7: p.nibble = 4'h2;
            5'd8: begin
                p.nibble = 4'h2;
                p.hold_us = 16'd100;
            end
            5'd9, 5'd10: p.nibble = 4'h2;
            5'd11: p.nibble = 4'h8;
            5'd12, 5'd16: begin
                p.nibble = 4'h8;
                p.hold_us = 16'd53;
            end
            5'd13, 5'd14, 5'd17, 5'd18, 5'd21, 5'd22, 5'd25, 5'd26: p.nibble = 4'h0;
            5'd15: p.nibble = 4'h8;
            5'd19: p.nibble = 4'h1;
            5'd20: begin
                p.nibble = 4'h1;
                p.hold_us = 16'd3000;
            end
            5'd23: p.nibble = 4'h6;
            5'd24: begin
                p.nibble = 4'h6;
                p.hold_us = 16'd3000;
            end
            5'd27: p.nibble = 4'hC;
            5'd28: begin
                p.nibble = 4'hC;
                p.hold_us = 16'd3000;
            end
            default: p.nibble = 4'h0;
        endcase
        return p;
    endfunction

endpackage

>>> src/clcd_front.sv
module clcd_front
    import clcd_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [7:0]  s_value,
    input  logic [15:0] s_delay_us,
    input  logic        s_row,
    input  logic [5:0]  s_column,
    input  logic        q_full,
    output logic        q_push,
    output lcd_job_t    q_job
);

    logic known;

    assign s_ready = ~q_full;

    always_comb begin
        known = 1'b1;
        q_job.op = OP_BYTE;
        q_job.data = s_value;
        q_job.rs = 1'b0;
        q_job.wait_us = s_delay_us;
        case (s_action)
            ACT_INIT: q_job.op = OP_INIT;
            ACT_NIBBLE: begin
                q_job.op = OP_NIBBLE;
                q_job.data = {4'h0, s_value[3:0]};
            end
            ACT_BYTE: q_job.op = OP_BYTE;
            ACT_CHAR: begin
                q_job.rs = 1'b1;
                q_job.wait_us = CHAR_WAIT_US;
            end
            ACT_CURSOR: begin
                q_job.data = {1'b1, s_row, s_column};
                q_job.wait_us = CHAR_WAIT_US;
            end
            default: known = 1'b0;
        endcase
    end

    // unknown requests are taken and dropped
    assign q_push = s_valid & ~q_full & known;

endmodule

>>> src/clcd_queue.sv
module clcd_queue
    import clcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lcd_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output lcd_job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    lcd_job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> src/clcd_back.sv
module clcd_back
    import clcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  lcd_job_t    head_job,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_bus_nibble,
    output logic        m_reg_select,
    output logic        m_enable_pin,
    output logic [15:0] m_hold_us,
    output logic        m_last
);

    logic [4:0] step_reg, step_next;
    logic m_valid_reg, m_valid_next;
    pin_state_t pin_reg;
    logic last_reg;
    pin_state_t pin;
    logic [4:0] final_step;
    logic is_last;
    logic advance;

    always_comb begin
        pin.rs = head_job.rs;
        pin.en = ~step_reg[0];
        pin.hold_us = STROBE_US;
        pin.nibble = head_job.data[3:0];
        final_step = BYTE_LAST_STEP;
        case (head_job.op)
            OP_INIT: begin
                pin = init_step(step_reg);
                final_step = INIT_LAST_STEP;
            end
            OP_NIBBLE: begin
                final_step = NIBBLE_LAST_STEP;
                if (step_reg[0]) begin
                    pin.hold_us = head_job.wait_us;
                end
            end
            default: begin
                // high nibble first, request's wait after the low one
                if (!step_reg[1]) begin
                    pin.nibble = head_job.data[7:4];
                end
                if (step_reg == BYTE_LAST_STEP) begin
                    pin.hold_us = head_job.wait_us;
                end
            end
        endcase
        is_last = (step_reg == final_step);
    end

    // output register frees when empty or when its beat is taken
    assign advance = head_valid & (~m_valid_reg | m_ready);
    assign pop = advance & is_last;

    always_comb begin
        step_next = step_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
            step_next = is_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pin_reg <= pin;
            last_reg <= is_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_bus_nibble = pin_reg.nibble;
    assign m_reg_select = pin_reg.rs;
    assign m_enable_pin = pin_reg.en;
    assign m_hold_us = pin_reg.hold_us;
    assign m_last = last_reg;

endmodule

>>> src/char_lcd_four_bit_write_sequencer.sv
// channel | direction | beat contents
// s_      | in        | action, value, delay_us, row, column
// m_      | out       | bus_nibble, reg_select, enable_pin, hold_us, last
//
// one pin state leaves per cycle unless m_ready or an empty queue stalls it;
// a nibble command ends at step NIBBLE_LAST_STEP, a byte, character or
// cursor request at BYTE_LAST_STEP, power-up at INIT_LAST_STEP; requests
// queue in a small fifo and are taken until it is full, also in a stall.
// synchronous active-low reset empties the queue and the output register.
module char_lcd_four_bit_write_sequencer
    import clcd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [7:0]  s_value,
    input  logic [15:0] s_delay_us,
    input  logic        s_row,
    input  logic [5:0]  s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_bus_nibble,
    output logic        m_reg_select,
    output logic        m_enable_pin,
    output logic [15:0] m_hold_us,
    output logic        m_last
);

    logic q_full;
    logic q_push;
    lcd_job_t q_job;
    logic q_pop;
    logic head_valid;
    lcd_job_t head_job;

    clcd_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_value    (s_value),
        .s_delay_us (s_delay_us),
        .s_row      (s_row),
        .s_column   (s_column),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    clcd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    clcd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bus_nibble (m_bus_nibble),
        .m_reg_select (m_reg_select),
        .m_enable_pin (m_enable_pin),
        .m_hold_us    (m_hold_us),
        .m_last       (m_last)
    );

endmodule
